/* hw/rtl/mm_pkg.sv */
// shared types and constants for the matrix multiply core
package mm_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [1:0] CFG_COLS_B    = 2'd2;

  // field widths fixed by the interface
  localparam int unsigned DIM_REG_W = 4;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned IN_ELEM_W = 16;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned OUT_W     = 32;

  // controller to datapath command
  typedef struct packed {
    logic we_a;       // load item for store a
    logic we_b;       // load item for store b
    logic issue;      // one product term is read this cycle
    logic first_k;    // first term of an output element
    logic last_k;     // final term of an output element
    logic last_elem;  // final term of the whole product
  } ctl_cmd_t;

endpackage

/* hw/rtl/mm_ram.sv */
// generic single write port ram with registered read
module mm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mm_ctrl.sv */
// controller: config registers, handshake and the row/column/term walk
module mm_ctrl #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [1:0]                         in_mode,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [mm_pkg::DIM_REG_W-1:0]       cfg_data,
  output logic                               busy,
  output mm_pkg::ctl_cmd_t                   cmd,
  output logic [$clog2(MAX_DIM)-1:0]         r_idx,
  output logic [$clog2(MAX_DIM)-1:0]         c_idx,
  output logic [$clog2(MAX_DIM)-1:0]         k_idx
);

  localparam int unsigned DW = $clog2(MAX_DIM);
  localparam int unsigned RW = mm_pkg::DIM_REG_W;
  localparam logic [6:0]  MAX_DIM_7 = 7'(MAX_DIM);
  localparam logic [DW-1:0] DIM_TOP = DW'(MAX_DIM - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [RW-1:0]   rows_a_r, inner_dim_r, cols_b_r;
  logic [DW-1:0]   nr_m1_r, nk_m1_r, nc_m1_r;
  logic [DW-1:0]   nr_m1_nxt, nk_m1_nxt, nc_m1_nxt;
  logic [DW-1:0]   r_r, c_r, k_r;
  logic [DW-1:0]   r_nxt, c_nxt, k_nxt;
  logic            accept;
  logic            k_end, c_end, r_end;

  // zero acts as one, anything above the grid acts as the grid size
  function automatic logic [DW-1:0] dim_m1(input logic [RW-1:0] v);
    logic [DW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (7'(v) > MAX_DIM_7) begin
      res = DIM_TOP;
    end else begin
      res = DW'(v - RW'(1));
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= RW'(8);
      inner_dim_r <= RW'(8);
      cols_b_r    <= RW'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mm_pkg::CFG_ROWS_A:    rows_a_r    <= cfg_data;
        mm_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_data;
        mm_pkg::CFG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy   = (state_r == ST_RUN);
  assign accept = start && !busy;

  assign k_end = (k_r == nk_m1_r);
  assign c_end = (c_r == nc_m1_r);
  assign r_end = (r_r == nr_m1_r);

  always_comb begin
    state_nxt = state_r;
    nr_m1_nxt = nr_m1_r;
    nk_m1_nxt = nk_m1_r;
    nc_m1_nxt = nc_m1_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == mm_pkg::MODE_COMPUTE)) begin
          nr_m1_nxt = dim_m1(rows_a_r);
          nk_m1_nxt = dim_m1(inner_dim_r);
          nc_m1_nxt = dim_m1(cols_b_r);
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!k_end) begin
          k_nxt = k_r + DW'(1);
        end else begin
          k_nxt = '0;
          if (!c_end) begin
            c_nxt = c_r + DW'(1);
          end else begin
            c_nxt = '0;
            if (r_end) begin
              state_nxt = ST_IDLE;
            end else begin
              r_nxt = r_r + DW'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
      nr_m1_r <= '0;
      nk_m1_r <= '0;
      nc_m1_r <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      nr_m1_r <= nr_m1_nxt;
      nk_m1_r <= nk_m1_nxt;
      nc_m1_r <= nc_m1_nxt;
    end
  end

  always_comb begin
    cmd.we_a      = accept && (in_mode == mm_pkg::MODE_LOAD_A);
    cmd.we_b      = accept && (in_mode == mm_pkg::MODE_LOAD_B);
    cmd.issue     = busy;
    cmd.first_k   = (k_r == '0);
    cmd.last_k    = k_end;
    cmd.last_elem = k_end && c_end && r_end;
  end

  assign r_idx = r_r;
  assign c_idx = c_r;
  assign k_idx = k_r;

endmodule

/* hw/rtl/mm_datapath.sv */
// datapath: element stores, multiply, accumulate and saturate
module mm_datapath #(
  parameter int unsigned MAX_DIM       = 8,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mm_pkg::ctl_cmd_t                     cmd,
  input  logic [$clog2(MAX_DIM)-1:0]           r_idx,
  input  logic [$clog2(MAX_DIM)-1:0]           c_idx,
  input  logic [$clog2(MAX_DIM)-1:0]           k_idx,
  input  logic [mm_pkg::POS_W-1:0]             in_row_index,
  input  logic [mm_pkg::POS_W-1:0]             in_col_index,
  input  logic signed [mm_pkg::IN_ELEM_W-1:0]  in_element_value,
  output logic                                 out_valid,
  output logic [mm_pkg::POS_W-1:0]             out_row,
  output logic [mm_pkg::POS_W-1:0]             out_col,
  output logic signed [mm_pkg::OUT_W-1:0]      out_value,
  output logic                                 out_saturated,
  output logic                                 out_last
);

  localparam int unsigned DW    = $clog2(MAX_DIM);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = ELEMENT_WIDTH;
  localparam int unsigned PW    = 2 * ELEMENT_WIDTH;
  localparam int unsigned AccW  = mm_pkg::ACC_W;
  localparam int unsigned OW    = mm_pkg::OUT_W;
  localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);
  localparam logic [6:0]    DIM_7 = 7'(MAX_DIM);

  logic            in_grid;
  logic [AW-1:0]   waddr, raddr_a, raddr_b;
  logic [EW-1:0]   wdata, rdata_a, rdata_b;

  // loads outside the grid are dropped
  assign in_grid = (7'(in_row_index) < DIM_7) && (7'(in_col_index) < DIM_7);
  assign waddr   = AW'(AW'(in_row_index) * DIM_A) + AW'(in_col_index);
  assign wdata   = EW'($unsigned(in_element_value));
  assign raddr_a = AW'(AW'(r_idx) * DIM_A) + AW'(k_idx);
  assign raddr_b = AW'(AW'(k_idx) * DIM_A) + AW'(c_idx);

  mm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.we_a && in_grid),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.we_b && in_grid),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // stage 1: ram read data, stage 2: product, stage 3: accumulate and output
  logic                    s1_vld_r, s2_vld_r;
  logic                    s1_first_r, s1_lastk_r, s1_last_r;
  logic                    s2_first_r, s2_lastk_r, s2_last_r;
  logic [DW-1:0]           s1_r_r, s1_c_r, s2_r_r, s2_c_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [AccW-1:0]  acc_r, sum;
  logic                    sum_ovf;
  logic                    out_valid_r, out_sat_r, out_last_r;
  logic [mm_pkg::POS_W-1:0] out_row_r, out_col_r;
  logic signed [OW-1:0]    out_value_r;

  assign sum     = (s2_first_r ? '0 : acc_r) + AccW'(prod_r);
  // clipped unless the upper bits are all copies of the sign bit
  assign sum_ovf = !((&sum[AccW-1:OW-1]) || !(|sum[AccW-1:OW-1]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= cmd.issue;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r && s2_lastk_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.first_k;
    s1_lastk_r <= cmd.last_k;
    s1_last_r  <= cmd.last_elem;
    s1_r_r     <= r_idx;
    s1_c_r     <= c_idx;
    s2_first_r <= s1_first_r;
    s2_lastk_r <= s1_lastk_r;
    s2_last_r  <= s1_last_r;
    s2_r_r     <= s1_r_r;
    s2_c_r     <= s1_c_r;
    prod_r     <= $signed(rdata_a) * $signed(rdata_b);
    if (s2_vld_r) begin
      acc_r <= sum;
      if (s2_lastk_r) begin
        out_row_r  <= mm_pkg::POS_W'(s2_r_r);
        out_col_r  <= mm_pkg::POS_W'(s2_c_r);
        out_sat_r  <= sum_ovf;
        out_last_r <= s2_last_r;
        if (!sum_ovf) begin
          out_value_r <= sum[OW-1:0];
        end else if (sum[AccW-1]) begin
          out_value_r <= {1'b1, {(OW-1){1'b0}}};
        end else begin
          out_value_r <= {1'b0, {(OW-1){1'b1}}};
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

endmodule

/* hw/rtl/matrix_multiply_core.sv */
// top level of the fixed point dense matrix multiply core
//
// usage notes
// - input items are taken at a clock edge with start high and busy low
// - in_mode picks the item: load an element of a, load an element of b, or compute
// - busy stays low during a load, so loads can stream one per cycle
// - loads with a row or column outside the grid are dropped
// - a compute item raises busy until the whole product has been walked, one product term
//   per cycle, set by the single read port of each element store
// - each product element is strobed on out_valid for one cycle, row-major,
//   with out_last on the final one; each comes out once its last term has passed
//   the read, product and accumulate stages
// - the receiver cannot stall: results must be taken when strobed
// - shape registers are to be written through cfg_we/cfg_index/cfg_data while idle, a rule
//   the block leaves to the user; zero acts as one and values above the grid act as the grid size
// - reset sets all three shape registers to 8 and clears the control path;
//   the element stores are not cleared and hold garbage until loaded
module matrix_multiply_core #(
  parameter int unsigned MAX_DIM       = 8,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_mode,
  input  logic [mm_pkg::POS_W-1:0]             in_row_index,
  input  logic [mm_pkg::POS_W-1:0]             in_col_index,
  input  logic signed [mm_pkg::IN_ELEM_W-1:0]  in_element_value,
  // result channel
  output logic                                 out_valid,
  output logic [mm_pkg::POS_W-1:0]             out_row,
  output logic [mm_pkg::POS_W-1:0]             out_col,
  output logic signed [mm_pkg::OUT_W-1:0]      out_value,
  output logic                                 out_saturated,
  output logic                                 out_last,
  // configuration port
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [mm_pkg::DIM_REG_W-1:0]         cfg_data
);

  localparam int unsigned DW = $clog2(MAX_DIM);

  mm_pkg::ctl_cmd_t cmd;
  logic [DW-1:0]    r_idx, c_idx, k_idx;

  // walks r, c, k and issues one term per cycle
  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .cmd       (cmd),
    .r_idx     (r_idx),
    .c_idx     (c_idx),
    .k_idx     (k_idx)
  );

  // stores, multiplier and accumulator, three stages deep
  mm_datapath #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .r_idx            (r_idx),
    .c_idx            (c_idx),
    .k_idx            (k_idx),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_saturated    (out_saturated),
    .out_last         (out_last)
  );

endmodule

/* tb/sv/matrix_multiply_core_tb.sv */
// self-checking testbench for the fixed point dense matrix multiply core
`timescale 1ns / 100ps

module matrix_multiply_core_tb;

  localparam int GRID = 8;                // element store is GRID x GRID
  localparam int SETTLE = 16;             // quiet cycles before a shape write
  localparam int STALL_LIMIT = 1000;      // cycles with no traffic before giving up
  localparam int RAND_ITEMS = 205;        // random items after the directed table
  localparam int DIR_LEN = 27;

  // mode 3 is not a real operation, the block must drop it
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // register index with nothing behind it
  localparam logic [1:0] CFG_NONE = 2'd3;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_t;

  // one row of the directed table: a shape write or an item,
  // optionally with the single product element typed in by hand
  typedef struct packed {
    step_kind_t  kind;
    logic [1:0]  reg_idx;
    logic [3:0]  reg_val;
    logic [1:0]  mode;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] elem;
    logic        typed;
    logic [31:0] typed_value;
    logic        typed_sat;
  } dir_step_t;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               sat;
    logic               last;
  } product_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = mm_pkg::MODE_LOAD_A;
  logic [2:0]  in_row_index = '0;
  logic [2:0]  in_col_index = '0;
  logic [15:0] in_element_value = '0;

  logic        out_valid;
  logic [2:0]  out_row;
  logic [2:0]  out_col;
  logic [31:0] out_value;
  logic        out_saturated;
  logic        out_last;

  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = mm_pkg::CFG_ROWS_A;
  logic [3:0]  cfg_data = '0;

  // mirror of the block: element stores, which entries were loaded, shape registers
  logic signed [15:0] a_elems [GRID*GRID];
  logic signed [15:0] b_elems [GRID*GRID];
  bit                 a_loaded [GRID*GRID];
  bit                 b_loaded [GRID*GRID];
  logic [3:0]         rows_cfg = 4'd8;
  logic [3:0]         inner_cfg = 4'd8;
  logic [3:0]         cols_cfg = 4'd8;

  // product elements still owed by the block, oldest first
  product_elem_t pending_products [$];

  int err_count = 0;
  int quiet_cycles = 0;

  dir_step_t dir_steps [DIR_LEN];

  matrix_multiply_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_saturated    (out_saturated),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // a shape register of zero counts as one, anything past the grid as the grid
  function automatic int eff_dim(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > GRID) return GRID;
    return int'(v);
  endfunction

  // apply one accepted item: loads land in the stores, a compute queues
  // every product element in row-major order
  function automatic void predict_item(logic [1:0] m, logic [2:0] r, logic [2:0] c,
                                       logic [15:0] v);
    int nr;
    int nk;
    int nc;
    longint acc;
    product_elem_t e;
    if (m == mm_pkg::MODE_LOAD_A) begin
      a_elems[r*GRID + c] = v;
      a_loaded[r*GRID + c] = 1'b1;
    end else if (m == mm_pkg::MODE_LOAD_B) begin
      b_elems[r*GRID + c] = v;
      b_loaded[r*GRID + c] = 1'b1;
    end else if (m == mm_pkg::MODE_COMPUTE) begin
      nr = eff_dim(rows_cfg);
      nk = eff_dim(inner_cfg);
      nc = eff_dim(cols_cfg);
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          // exact q16.16 sum, then clip to 32 bits
          acc = 0;
          for (int k = 0; k < nk; k++)
            acc += longint'(a_elems[i*GRID + k]) * longint'(b_elems[k*GRID + j]);
          e.row = 3'(i);
          e.col = 3'(j);
          e.sat = 1'b0;
          if (acc > SUM_MAX) begin
            e.value = 32'h7fff_ffff;
            e.sat = 1'b1;
          end else if (acc < SUM_MIN) begin
            e.value = 32'h8000_0000;
            e.sat = 1'b1;
          end else begin
            e.value = acc[31:0];
          end
          e.last = (i == nr - 1) && (j == nc - 1);
          pending_products.push_back(e);
        end
      end
    end
  endfunction

  // sender gaps: mostly back to back or short, now and then a long pause
  function automatic int gap_len(bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // element values; the large-magnitude set pushes sums past 32 bits
  function automatic logic [15:0] rand_elem(bit big_vals);
    if (big_vals) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h8001;
        default: return 16'($urandom_range(16'h7000, 16'h7fff));
      endcase
    end
    case ($urandom_range(0, 19))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hffff;
      3: return 16'h8000;
      4: return 16'h7fff;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // present one item and hold it until the block takes it; start stays high
  // afterwards so the next item can follow with no gap
  task automatic send_item(logic [1:0] m, logic [2:0] r, logic [2:0] c, logic [15:0] v,
                           int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_row_index <= r;
    in_col_index <= c;
    in_element_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // let every owed product element drain, then give the block time to settle
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_products.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // shape registers only change while the block is idle
  task automatic write_dim_reg(logic [1:0] idx, logic [3:0] val);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mm_pkg::CFG_ROWS_A:    rows_cfg = val;
      mm_pkg::CFG_INNER_DIM: inner_cfg = val;
      mm_pkg::CFG_COLS_B:    cols_cfg = val;
      default: ;
    endcase
  endtask

  // every strobed element is checked against the oldest one owed
  always @(posedge clk) begin
    product_elem_t want;
    if (rst_n && out_valid) begin
      if (pending_products.size() == 0) begin
        $error("product element row %0d col %0d with none expected", out_row, out_col);
        err_count++;
      end else begin
        want = pending_products.pop_front();
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          err_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          err_count++;
        end
        if (out_value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, out_value);
          err_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("out_saturated: expected %0d, got %0d", want.sat, out_saturated);
          err_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          err_count++;
        end
      end
    end
  end

  // watchdog: any item taken, element strobed or register written counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_step_t st;
    int random_items;
    int phase;
    int phase_len;
    int n;
    int roll;
    int pick;
    int nr;
    int nk;
    int nc;
    bit big_vals;
    bit burst;
    bit done;
    logic [3:0] sr;
    logic [3:0] sk;
    logic [3:0] sc;
    logic [1:0] m;
    logic [2:0] r;
    logic [2:0] c;
    logic [15:0] v;
    int missing [$];

    // directed table: one row of a times one column of b, with sums driven
    // past both 32-bit limits, a dropped mode, a write to an index with no
    // register behind it, and out-of-range shape values
    dir_steps = '{
      '{STEP_CFG,  mm_pkg::CFG_ROWS_A,    4'd1,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0},
      '{STEP_CFG,  mm_pkg::CFG_INNER_DIM, 4'd3,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0},
      '{STEP_CFG,  mm_pkg::CFG_COLS_B,    4'd1,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h8000, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd1, 16'h8000, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd2, 16'h8000, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_B,
        3'd0, 3'd0, 16'h8000, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_B,
        3'd1, 3'd0, 16'h8000, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_B,
        3'd2, 3'd0, 16'h8000, 1'b0, 32'h0, 1'b0},
      // three products of -128.0 * -128.0 clip at the top
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_COMPUTE,
        3'd0, 3'd0, 16'h0, 1'b1, 32'h7fff_ffff, 1'b1},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_B,
        3'd0, 3'd0, 16'h7fff, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_B,
        3'd1, 3'd0, 16'h7fff, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_B,
        3'd2, 3'd0, 16'h7fff, 1'b0, 32'h0, 1'b0},
      // most negative times most positive, three times, clips at the bottom
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_COMPUTE,
        3'd0, 3'd0, 16'h0, 1'b1, 32'h8000_0000, 1'b1},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  MODE_UNUSED,
        3'd7, 3'd7, 16'hffff, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_A,
        3'd7, 3'd7, 16'h7fff, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_B,
        3'd7, 3'd7, 16'hffff, 1'b0, 32'h0, 1'b0},
      '{STEP_CFG,  CFG_NONE,              4'd15, mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0},
      // shape must be untouched by the writes above
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_COMPUTE,
        3'd0, 3'd0, 16'h0, 1'b1, 32'h8000_0000, 1'b1},
      '{STEP_CFG,  mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0},
      '{STEP_CFG,  mm_pkg::CFG_INNER_DIM, 4'd0,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0},
      '{STEP_CFG,  mm_pkg::CFG_COLS_B,    4'd0,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0},
      // zero shape acts as 1x1x1: -128.0 * (just under 128.0)
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_COMPUTE,
        3'd0, 3'd0, 16'h0, 1'b1, 32'hc000_8000, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_A,
        3'd0, 3'd0, 16'h0001, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_COMPUTE,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_LOAD_B,
        3'd0, 3'd0, 16'hffff, 1'b0, 32'h0, 1'b0},
      '{STEP_ITEM, mm_pkg::CFG_ROWS_A,    4'd0,  mm_pkg::MODE_COMPUTE,
        3'd0, 3'd0, 16'h0,    1'b0, 32'h0, 1'b0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_LEN; i++) begin
      st = dir_steps[i];
      if (st.kind == STEP_CFG) begin
        write_dim_reg(st.reg_idx, st.reg_val);
      end else begin
        send_item(st.mode, st.row, st.col, st.elem, gap_len(1'b0));
        if (st.mode == mm_pkg::MODE_COMPUTE && st.typed)
          pending_products.push_back('{row: 3'd0, col: 3'd0, value: st.typed_value,
                                       sat: st.typed_sat, last: 1'b1});
        else
          predict_item(st.mode, st.row, st.col, st.elem);
      end
    end

    // random phases: pick a shape, fill whatever it needs that was never
    // loaded, then mix overwrites and computes, with some noise items
    random_items = 0;
    for (phase = 0; random_items < RAND_ITEMS; phase++) begin
      case (phase)
        0: begin sr = 4'd1;  sk = 4'd1;  sc = 4'd1;  end
        1: begin sr = 4'd2;  sk = 4'd8;  sc = 4'd3;  end
        2: begin sr = 4'd0;  sk = 4'd15; sc = 4'd1;  end
        3: begin sr = 4'd8;  sk = 4'd8;  sc = 4'd8;  end
        4: begin sr = 4'd15; sk = 4'd3;  sc = 4'd15; end
        default: begin
          sr = 4'($urandom_range(0, 15));
          sk = 4'($urandom_range(0, 15));
          sc = 4'($urandom_range(0, 15));
        end
      endcase
      write_dim_reg(mm_pkg::CFG_ROWS_A, sr);
      write_dim_reg(mm_pkg::CFG_INNER_DIM, sk);
      write_dim_reg(mm_pkg::CFG_COLS_B, sc);
      nr = eff_dim(rows_cfg);
      nk = eff_dim(inner_cfg);
      nc = eff_dim(cols_cfg);
      big_vals = ($urandom_range(0, 2) == 0);
      burst = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 30);
      n = 0;
      done = 1'b0;
      while (!done) begin
        // entries this shape reads that have never been loaded
        missing.delete();
        for (int i = 0; i < nr; i++)
          for (int k = 0; k < nk; k++)
            if (!a_loaded[i*GRID + k]) missing.push_back(i*GRID + k);
        for (int k = 0; k < nk; k++)
          for (int j = 0; j < nc; j++)
            if (!b_loaded[k*GRID + j]) missing.push_back(GRID*GRID + k*GRID + j);

        roll = $urandom_range(0, 99);
        r = 3'($urandom_range(0, 7));
        c = 3'($urandom_range(0, 7));
        v = rand_elem(big_vals);
        if (roll < 8) begin
          // noise: dropped mode or a load anywhere in the grid
          m = $urandom_range(0, 1) ? MODE_UNUSED : 2'($urandom_range(0, 1));
          v = 16'($urandom_range(0, 16'hffff));
        end else if (missing.size() != 0) begin
          pick = missing[$urandom_range(0, missing.size() - 1)];
          m = (pick >= GRID*GRID) ? mm_pkg::MODE_LOAD_B : mm_pkg::MODE_LOAD_A;
          r = 3'((pick % (GRID*GRID)) / GRID);
          c = 3'(pick % GRID);
        end else if (n >= phase_len || roll < 35) begin
          m = mm_pkg::MODE_COMPUTE;
          done = (n >= phase_len);
        end else if ($urandom_range(0, 1)) begin
          m = mm_pkg::MODE_LOAD_A;
          r = 3'($urandom_range(0, nr - 1));
          c = 3'($urandom_range(0, nk - 1));
        end else begin
          m = mm_pkg::MODE_LOAD_B;
          r = 3'($urandom_range(0, nk - 1));
          c = 3'($urandom_range(0, nc - 1));
        end
        send_item(m, r, c, v, gap_len(burst));
        predict_item(m, r, c, v);
        n++;
        if (m != MODE_UNUSED) random_items++;
      end
    end

    wait_quiet();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
